FILE: rtl/bmn_pkg.sv
package bmn_pkg;

  localparam int PAGE_COUNT = 6;
  localparam int NODE_PAGE_INDEX = 1;
  localparam int MAX_NODES = 64;

  localparam logic [2:0] PAGE_LAST = 3'(PAGE_COUNT - 1);
  localparam logic [2:0] NODE_PAGE = 3'(NODE_PAGE_INDEX);
  localparam logic [6:0] NODE_LIMIT = 7'(MAX_NODES);

  localparam logic [1:0] OP_SHORT = 2'd0;
  localparam logic [1:0] OP_LONG  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] ADDR_IDLE_TIMEOUT = 3'd0;
  localparam logic [2:0] ADDR_VISIBLE_ROWS = 3'd4;

  localparam logic [3:0] VISIBLE_ROWS_RESET = 4'd6;

  typedef enum logic [1:0] {
    MODE_MENU   = 2'd0,
    MODE_PAGE   = 2'd1,
    MODE_DETAIL = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  menu_pos;
    logic [2:0]  page_index;
    logic [6:0]  focus_index;
    logic [5:0]  detail_index;
    logic [15:0] idle_count;
    logic        blank_flag;
  } nav_state_t;

  typedef struct packed {
    logic [1:0] ui_mode;
    logic [2:0] menu_position;
    logic [2:0] current_page;
    logic [6:0] focus_position;
    logic [5:0] detail_node;
    logic       node_cursor_valid;
    logic [6:0] list_first;
    logic       screen_blanked;
  } nav_result_t;

endpackage

FILE: rtl/bmn_core.sv
module bmn_core (
  input  bmn_pkg::nav_state_t  state_cur,
  input  logic [1:0]           opcode,
  input  logic [6:0]           node_count,
  input  logic [15:0]          idle_timeout,
  input  logic [3:0]           visible_rows,
  output bmn_pkg::nav_state_t  state_nxt,
  output bmn_pkg::nav_result_t result
);
  import bmn_pkg::*;

  function automatic logic on_node_page(nav_state_t s);
    return (s.mode == MODE_PAGE) && (s.page_index == NODE_PAGE);
  endfunction

  function automatic logic [6:0] ring_size(nav_state_t s, logic [6:0] n);
    return on_node_page(s) ? (n + 7'd2) : 7'd2;
  endfunction

  function automatic nav_state_t clamp(nav_state_t s, logic [6:0] n);
    nav_state_t r;
    logic [6:0] rs;
    r  = s;
    rs = ring_size(s, n);
    if (s.mode == MODE_DETAIL) begin
      if (n == 7'd0) begin
        r.mode        = MODE_PAGE;
        r.page_index  = NODE_PAGE;
        r.focus_index = 7'd0;
      end else if ({1'b0, s.detail_index} >= n) begin
        r.detail_index = 6'(n - 7'd1);
      end
    end else if (s.mode == MODE_PAGE) begin
      if (s.focus_index >= rs) r.focus_index = rs - 7'd1;
    end
    return r;
  endfunction

  function automatic nav_state_t press_short(nav_state_t s, logic [6:0] n);
    nav_state_t r;
    r = s;
    if (s.mode == MODE_MENU) begin
      r.menu_pos = (s.menu_pos == PAGE_LAST) ? 3'd0 : s.menu_pos + 3'd1;
    end else begin
      // focus is already below the ring size after the clamp
      r.focus_index = ((s.focus_index + 7'd1) >= ring_size(s, n)) ? 7'd0
                                                                  : s.focus_index + 7'd1;
    end
    return r;
  endfunction

  function automatic nav_state_t press_long(nav_state_t s, logic [6:0] n);
    nav_state_t r;
    logic [6:0] back;
    r    = s;
    back = ring_size(s, n) - 7'd2;
    if (s.mode == MODE_MENU) begin
      r.page_index  = s.menu_pos;
      r.focus_index = 7'd0;
      r.mode        = MODE_PAGE;
    end else if (s.mode == MODE_DETAIL) begin
      if (s.focus_index == 7'd0 || n == 7'd0) begin
        r.mode        = MODE_PAGE;
        r.page_index  = NODE_PAGE;
        r.focus_index = {1'b0, s.detail_index};
      end else begin
        r.detail_index = ({1'b0, s.detail_index} + 7'd1 >= n) ? 6'd0
                                                             : s.detail_index + 6'd1;
      end
    end else if (s.page_index == NODE_PAGE && s.focus_index < back) begin
      r.detail_index = s.focus_index[5:0];
      r.focus_index  = 7'd1;
      r.mode         = MODE_DETAIL;
    end else if (s.focus_index == back) begin
      r.mode = MODE_MENU;
    end else begin
      r.page_index  = (s.page_index == PAGE_LAST) ? 3'd0 : s.page_index + 3'd1;
      r.focus_index = 7'd0;
    end
    return r;
  endfunction

  logic [6:0]  n_sat;
  logic [15:0] idle_inc;
  nav_state_t  ev;
  nav_state_t  fin;
  logic        cursor_valid;
  logic [6:0]  rows_ext;

  assign n_sat    = (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
  assign idle_inc = (state_cur.idle_count == 16'hFFFF) ? 16'hFFFF
                                                       : state_cur.idle_count + 16'd1;
  assign rows_ext = {3'd0, visible_rows};

  always_comb begin
    ev = state_cur;
    case (opcode) inside
      OP_SHORT, OP_LONG: begin
        // a press on a blanked panel only wakes it
        if (state_cur.blank_flag) begin
          ev.blank_flag = 1'b0;
        end else if (opcode == OP_SHORT) begin
          ev = press_short(clamp(state_cur, n_sat), n_sat);
        end else begin
          ev = press_long(clamp(state_cur, n_sat), n_sat);
        end
        ev.idle_count = 16'd0;
      end
      OP_TICK: begin
        ev.idle_count = idle_inc;
        if (!state_cur.blank_flag && idle_timeout != 16'd0 && idle_inc >= idle_timeout)
          ev.blank_flag = 1'b1;
      end
      default: ev = state_cur;
    endcase
  end

  assign fin          = ev.blank_flag ? ev : clamp(ev, n_sat);
  assign state_nxt    = fin;
  assign cursor_valid = on_node_page(fin) && (fin.focus_index < n_sat);

  always_comb begin
    result.ui_mode           = fin.mode;
    result.menu_position     = fin.menu_pos;
    result.current_page      = fin.page_index;
    result.focus_position    = fin.focus_index;
    result.detail_node       = fin.detail_index;
    result.node_cursor_valid = cursor_valid;
    result.screen_blanked    = fin.blank_flag;
    result.list_first        = 7'd0;
    if (cursor_valid && visible_rows != 4'd0 && fin.focus_index >= rows_ext)
      result.list_first = fin.focus_index - rows_ext + 7'd1;
  end

endmodule

FILE: rtl/button_menu_navigator_unit.sv
// An accepted request goes through the input register, then the update logic into the
//   result register that drives the out_ ports.
// Throughput: one request per cycle unless stalled; state updates once per request.
// Reset (rst_n low, synchronous): launcher menu, all cursors and the idle count at zero,
//   screen on, idle timeout 0 (blanking off), 6 visible node rows, both stages empty.
module button_menu_navigator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [6:0]  in_node_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_ui_mode,
  output logic [2:0]  out_menu_position,
  output logic [2:0]  out_current_page,
  output logic [6:0]  out_focus_position,
  output logic [5:0]  out_detail_node,
  output logic        out_node_cursor_valid,
  output logic [6:0]  out_list_first,
  output logic        out_screen_blanked,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bmn_pkg::*;

  logic [15:0] idle_timeout_r;
  logic [3:0]  visible_rows_r;

  logic        s1_valid_r;
  logic [1:0]  s1_opcode_r;
  logic [6:0]  s1_node_count_r;

  nav_state_t  state_r;
  nav_state_t  state_nxt;
  nav_result_t result_nxt;
  nav_result_t result_r;
  logic        out_valid_r;

  logic        out_free;
  logic        s1_fire;
  logic        cfg_wr;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= 16'd0;
      visible_rows_r <= VISIBLE_ROWS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_IDLE_TIMEOUT: idle_timeout_r <= pwdata[15:0];
        ADDR_VISIBLE_ROWS: visible_rows_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_IDLE_TIMEOUT: prdata = {16'd0, idle_timeout_r};
      ADDR_VISIBLE_ROWS: prdata = {28'd0, visible_rows_r};
      default:           prdata = 32'd0;
    endcase
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode_r     <= in_opcode;
      s1_node_count_r <= in_node_count;
    end
  end

  bmn_core u_core (
    .state_cur    (state_r),
    .opcode       (s1_opcode_r),
    .node_count   (s1_node_count_r),
    .idle_timeout (idle_timeout_r),
    .visible_rows (visible_rows_r),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{mode: MODE_MENU, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) state_r <= state_nxt;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) result_r <= result_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_ui_mode           = result_r.ui_mode;
  assign out_menu_position     = result_r.menu_position;
  assign out_current_page      = result_r.current_page;
  assign out_focus_position    = result_r.focus_position;
  assign out_detail_node       = result_r.detail_node;
  assign out_node_cursor_valid = result_r.node_cursor_valid;
  assign out_list_first        = result_r.list_first;
  assign out_screen_blanked    = result_r.screen_blanked;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed request did not produce a result");

  a_cursor_on_node_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_node_cursor_valid) |->
      (out_ui_mode == MODE_PAGE && out_current_page == NODE_PAGE))
    else $error("node cursor valid outside the nodes page");

  a_list_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_list_first <= out_focus_position))
    else $error("list window starts past the focus");

  a_menu_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_menu_position <= PAGE_LAST && out_current_page <= PAGE_LAST))
    else $error("menu or page index out of range");

endmodule
